[sv/frustum_plane_extract_and_point_test_unit_macros.svh]
// assertion macros used by the port-level checker
`ifndef FRUSTUM_PLANE_EXTRACT_AND_POINT_TEST_UNIT_MACROS_SVH
`define FRUSTUM_PLANE_EXTRACT_AND_POINT_TEST_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define FPE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define FPE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/fpe_pkg.sv]
// shared types, constants and helper functions of the frustum plane unit
package fpe_pkg;

	localparam int PLANE_COUNT_DEF = 6;
	localparam int PLANE_W = 3;
	localparam int CNT_W = 6;
	localparam int PAIR_COUNT = 8;
	localparam int PAIR_IDX_W = 3;
	localparam int APB_ADDR_W = 6;
	localparam int APB_DATA_W = 64;
	localparam int ACC_W = 68;
	localparam int DIV_W = 48;
	localparam int SQRT_STEPS = 32;
	localparam logic [3:0] LAST_ELEM = 4'd15;
	localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
	localparam logic [63:0] PAIR_DIAG_LO = 64'h0000_0000_0001_0000;
	localparam logic [63:0] PAIR_DIAG_HI = 64'h0001_0000_0000_0000;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_BASE,
		OP_PMUL,
		OP_MMUL,
		OP_RAW_W,
		OP_RAW_E,
		OP_SQ,
		OP_SQRT_INIT,
		OP_SQRT,
		OP_DIV_INIT,
		OP_DIV,
		OP_DIV_WR,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t op;
		logic [CNT_W-1:0] cnt;
		logic [PLANE_W-1:0] plane;
		logic [1:0] coef;
	} cmd_t;

	// matrix row that a plane combines with the last row
	function automatic logic [1:0] plane_row(input logic [PLANE_W-1:0] p);
		logic [1:0] r;
		r = p[2:1];
		return r;
	endfunction

	// true where the plane adds its row, false where it subtracts
	function automatic logic plane_add(input logic [PLANE_W-1:0] p);
		logic a;
		a = (p == 3'd0) || (p == 3'd3) || (p == 3'd4);
		return a;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
		logic signed [31:0] r;
		if (x > ACC_W'(64'sh7FFF_FFFF)) begin
			r = 32'sh7FFF_FFFF;
		end else if (x < -ACC_W'(64'sh8000_0000)) begin
			r = 32'sh8000_0000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [ACC_W-1:0] sext32(input logic signed [31:0] v);
		logic signed [ACC_W-1:0] r;
		r = {{(ACC_W-32){v[31]}}, v};
		return r;
	endfunction

endpackage

[sv/fpe_regs.sv]
// projection matrix register file behind the apb port
module fpe_regs import fpe_pkg::*; (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [APB_ADDR_W-1:0]               paddr,
	input  logic [APB_DATA_W-1:0]               pwdata,
	output logic [APB_DATA_W-1:0]               prdata,
	output logic                                pready,
	output logic [PAIR_COUNT-1:0][APB_DATA_W-1:0] proj
);

	logic [PAIR_COUNT-1:0][APB_DATA_W-1:0] proj_q;
	logic [PAIR_IDX_W-1:0] idx;

	assign idx = paddr[APB_ADDR_W-1:3];
	assign pready = 1'b1;
	assign prdata = proj_q[idx];
	assign proj = proj_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proj_q <= '0;
			proj_q[0] <= PAIR_DIAG_LO;
			proj_q[2] <= PAIR_DIAG_HI;
			proj_q[5] <= PAIR_DIAG_LO;
			proj_q[7] <= PAIR_DIAG_HI;
		end else if (psel && penable && pwrite) begin
			proj_q[idx] <= pwdata;
		end
	end

endmodule

[sv/fpe_ctrl.sv]
// sequencer for point tests and plane rebuilds
module fpe_ctrl import fpe_pkg::*; #(
	parameter int PLANE_COUNT = PLANE_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       command,
	input  logic [3:0] element_index,
	input  logic       out_stall,
	output logic       in_stall,
	output logic       out_valid,
	output cmd_t       cmd
);

	localparam logic [3:0] S_IDLE       = 4'd0;
	localparam logic [3:0] S_TEST       = 4'd1;
	localparam logic [3:0] S_TEST_DRAIN = 4'd2;
	localparam logic [3:0] S_EMIT       = 4'd3;
	localparam logic [3:0] S_MAT        = 4'd4;
	localparam logic [3:0] S_MAT_DRAIN  = 4'd5;
	localparam logic [3:0] S_RAW        = 4'd6;
	localparam logic [3:0] S_SQ         = 4'd7;
	localparam logic [3:0] S_SQ_DRAIN   = 4'd8;
	localparam logic [3:0] S_SQRT_INIT  = 4'd9;
	localparam logic [3:0] S_SQRT       = 4'd10;
	localparam logic [3:0] S_DIV_INIT   = 4'd11;
	localparam logic [3:0] S_DIV        = 4'd12;
	localparam logic [3:0] S_DIV_WR     = 4'd13;

	localparam logic [CNT_W-1:0] LAST_TEST = CNT_W'(PLANE_COUNT*4-1);
	localparam logic [CNT_W-1:0] LAST_MAT  = CNT_W'(63);
	localparam logic [CNT_W-1:0] LAST_RAW  = CNT_W'(7);
	localparam logic [CNT_W-1:0] LAST_SQ   = CNT_W'(2);
	localparam logic [CNT_W-1:0] LAST_SQRT = CNT_W'(SQRT_STEPS-1);
	localparam logic [CNT_W-1:0] LAST_DIV  = CNT_W'(DIV_W-1);
	localparam logic [PLANE_W-1:0] LAST_PLANE = PLANE_W'(PLANE_COUNT-1);

	logic [3:0] state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [PLANE_W-1:0] plane_q, plane_d;
	logic [1:0] coef_q, coef_d;
	logic out_valid_q, out_valid_d;

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		plane_d = plane_q;
		coef_d = coef_q;
		cmd = '{op: OP_NONE, cnt: cnt_q, plane: plane_q, coef: coef_q};
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = OP_CAPTURE;
					cnt_d = '0;
					if (command) begin
						state_d = S_TEST;
					end else if (element_index == LAST_ELEM) begin
						state_d = S_MAT;
					end
				end
			end
			S_TEST: begin
				cmd.op = (cnt_q[1:0] == 2'd0) ? OP_BASE : OP_PMUL;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == LAST_TEST) state_d = S_TEST_DRAIN;
			end
			S_TEST_DRAIN: state_d = S_EMIT;
			S_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.op = OP_EMIT;
					state_d = S_IDLE;
				end
			end
			S_MAT: begin
				cmd.op = OP_MMUL;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == LAST_MAT) state_d = S_MAT_DRAIN;
			end
			S_MAT_DRAIN: begin
				cnt_d = '0;
				plane_d = '0;
				state_d = S_RAW;
			end
			S_RAW: begin
				cmd.op = cnt_q[0] ? OP_RAW_E : OP_RAW_W;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == LAST_RAW) begin
					cnt_d = '0;
					state_d = S_SQ;
				end
			end
			S_SQ: begin
				cmd.op = OP_SQ;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == LAST_SQ) state_d = S_SQ_DRAIN;
			end
			S_SQ_DRAIN: state_d = S_SQRT_INIT;
			S_SQRT_INIT: begin
				cmd.op = OP_SQRT_INIT;
				cnt_d = '0;
				state_d = S_SQRT;
			end
			S_SQRT: begin
				cmd.op = OP_SQRT;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == LAST_SQRT) begin
					coef_d = '0;
					state_d = S_DIV_INIT;
				end
			end
			S_DIV_INIT: begin
				cmd.op = OP_DIV_INIT;
				cnt_d = '0;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.op = OP_DIV;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == LAST_DIV) state_d = S_DIV_WR;
			end
			S_DIV_WR: begin
				cmd.op = OP_DIV_WR;
				if (coef_q == 2'd3) begin
					cnt_d = '0;
					if (plane_q == LAST_PLANE) begin
						state_d = S_IDLE;
					end else begin
						plane_d = plane_q + 1'b1;
						state_d = S_RAW;
					end
				end else begin
					coef_d = coef_q + 1'b1;
					state_d = S_DIV_INIT;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		out_valid_d = out_valid_q;
		if (cmd.op == OP_EMIT) begin
			out_valid_d = 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			plane_q <= '0;
			coef_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			plane_q <= plane_d;
			coef_q <= coef_d;
			out_valid_q <= out_valid_d;
		end
	end

endmodule

[sv/fpe_dp.sv]
// datapath: stores, shared multiplier, square root and bit-serial divider
module fpe_dp import fpe_pkg::*; #(
	parameter int PLANE_COUNT = PLANE_COUNT_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  cmd_t                                  cmd,
	input  logic                                  command,
	input  logic [3:0]                            element_index,
	input  logic signed [31:0]                    element_value,
	input  logic signed [31:0]                    point_x,
	input  logic signed [31:0]                    point_y,
	input  logic signed [31:0]                    point_z,
	input  logic [PAIR_COUNT-1:0][APB_DATA_W-1:0] proj,
	output logic                                  inside_res
);

	localparam int PDEPTH = PLANE_COUNT * 4;
	localparam int PAW = $clog2(PDEPTH);

	logic signed [31:0] view_q [16];
	logic signed [31:0] plane_arr_q [PDEPTH];
	logic signed [31:0] m_q [16];
	logic signed [31:0] raw_q [4];
	logic signed [31:0] x_q, y_q, z_q, w_q;

	op_t op_s1;
	logic [CNT_W-1:0] cnt_s1;
	logic signed [63:0] prod_s1;

	logic signed [ACC_W-1:0] acc_q, base_q;
	logic [63:0] sumsq_q;
	logic [63:0] sq_n_q, sq_res_q, sq_bit_q;
	logic [DIV_W-1:0] div_d_q, div_quo_q;
	logic [31:0] div_rem_q;
	logic div_neg_q;
	logic outside_q, inside_res_q;

	logic [PAW-1:0] paddr_rd;
	logic signed [31:0] plane_rd;
	logic [3:0] maddr_rd;
	logic signed [31:0] m_rd;
	logic [3:0] proj_idx;
	logic [63:0] proj_pair;
	logic signed [31:0] proj_el;
	logic signed [31:0] mul_a, mul_b;
	logic signed [ACC_W-1:0] pmul_sum, mmul_sum, raw_sum;
	logic [63:0] sq_trial;
	logic [32:0] div_trial;
	logic div_ge;
	logic [31:0] len;
	logic signed [31:0] raw_sel, div_out;
	logic [31:0] raw_mag;

	// plane store read port: offset d first, then a, b, c
	always_comb begin
		paddr_rd = {cmd.cnt[PAW-1:2], cmd.cnt[1:0] - 2'd1};
		if (cmd.op == OP_BASE) paddr_rd = {cmd.cnt[PAW-1:2], 2'd3};
	end
	assign plane_rd = plane_arr_q[paddr_rd];

	assign maddr_rd = (cmd.op == OP_RAW_E) ? {cmd.cnt[2:1], plane_row(cmd.plane)}
	                                       : {cmd.cnt[2:1], 2'd3};
	assign m_rd = m_q[maddr_rd];

	// product term P[k*4+r] * V[c*4+k], cnt = c*16 + r*4 + k
	assign proj_idx = {cmd.cnt[1:0], cmd.cnt[3:2]};
	assign proj_pair = proj[proj_idx[3:1]];
	assign proj_el = proj_idx[0] ? proj_pair[63:32] : proj_pair[31:0];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_PMUL: begin
				mul_a = plane_rd;
				if (cmd.cnt[1:0] == 2'd1) mul_b = x_q;
				else if (cmd.cnt[1:0] == 2'd2) mul_b = y_q;
				else mul_b = z_q;
			end
			OP_MMUL: begin
				mul_a = proj_el;
				mul_b = view_q[{cmd.cnt[5:4], cmd.cnt[1:0]}];
			end
			OP_SQ: begin
				mul_a = raw_q[cmd.cnt[1:0]];
				mul_b = raw_q[cmd.cnt[1:0]];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign pmul_sum = ((cnt_s1[1:0] == 2'd1) ? base_q : acc_q)
	                + {{(ACC_W-64){prod_s1[63]}}, prod_s1};
	assign mmul_sum = ((cnt_s1[1:0] == 2'd0) ? '0 : acc_q)
	                + {{(ACC_W-48){prod_s1[63]}}, prod_s1[63:16]};
	assign raw_sum = plane_add(cmd.plane) ? sext32(w_q) + sext32(m_rd)
	                                      : sext32(w_q) - sext32(m_rd);

	assign sq_trial = sq_res_q + sq_bit_q;
	assign len = sq_res_q[31:0];
	assign div_trial = {div_rem_q, div_d_q[DIV_W-1]};
	assign div_ge = div_trial >= {1'b0, len};

	assign raw_sel = raw_q[cmd.coef];
	assign raw_mag = raw_sel[31] ? 32'(-raw_sel) : raw_sel;

	// sign and saturation of the truncated quotient
	always_comb begin
		if (div_neg_q) begin
			if (div_quo_q > DIV_W'(64'h8000_0000)) div_out = 32'sh8000_0000;
			else div_out = -div_quo_q[31:0];
		end else begin
			if (div_quo_q > DIV_W'(64'h7FFF_FFFF)) div_out = 32'sh7FFF_FFFF;
			else div_out = div_quo_q[31:0];
		end
	end

	assign inside_res = inside_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= OP_NONE;
			outside_q <= 1'b0;
			for (int i = 0; i < 16; i++) begin
				view_q[i] <= (i[1:0] == i[3:2]) ? ONE_Q16 : '0;
			end
			for (int i = 0; i < PDEPTH; i++) begin
				plane_arr_q[i] <= '0;
			end
		end else begin
			op_s1 <= cmd.op;
			if (cmd.op == OP_CAPTURE) begin
				if (!command) view_q[element_index] <= element_value;
				else outside_q <= 1'b0;
			end
			// distance plus y term at or below zero
			if (op_s1 == OP_PMUL && cnt_s1[1:0] == 2'd3 &&
			    (pmul_sum[ACC_W-1] || pmul_sum == '0)) begin
				outside_q <= 1'b1;
			end
			if (cmd.op == OP_DIV_WR) begin
				plane_arr_q[{cmd.plane, cmd.coef}] <= (len == '0) ? '0 : div_out;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		cnt_s1 <= cmd.cnt;
		if (cmd.op == OP_CAPTURE && command) begin
			x_q <= point_x;
			y_q <= point_y;
			z_q <= point_z;
		end
		if (cmd.op == OP_BASE) begin
			base_q <= (sext32(plane_rd) <<< 16) + (sext32(y_q) <<< 16);
		end
		unique case (op_s1)
			OP_PMUL: acc_q <= pmul_sum;
			OP_MMUL: begin
				acc_q <= mmul_sum;
				if (cnt_s1[1:0] == 2'd3) m_q[cnt_s1[5:2]] <= sat32(mmul_sum);
			end
			OP_SQ: sumsq_q <= ((cnt_s1[1:0] == 2'd0) ? '0 : sumsq_q) + prod_s1;
			default: ;
		endcase
		if (cmd.op == OP_RAW_W) w_q <= m_rd;
		if (cmd.op == OP_RAW_E) raw_q[cmd.cnt[2:1]] <= sat32(raw_sum);
		if (cmd.op == OP_SQRT_INIT) begin
			sq_n_q <= sumsq_q;
			sq_res_q <= '0;
			sq_bit_q <= 64'h4000_0000_0000_0000;
		end
		if (cmd.op == OP_SQRT) begin
			if (sq_n_q >= sq_trial) begin
				sq_n_q <= sq_n_q - sq_trial;
				sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
			end else begin
				sq_res_q <= sq_res_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end
		if (cmd.op == OP_DIV_INIT) begin
			div_d_q <= {raw_mag, 16'b0};
			div_rem_q <= '0;
			div_quo_q <= '0;
			div_neg_q <= raw_sel[31];
		end
		if (cmd.op == OP_DIV) begin
			div_rem_q <= div_ge ? 32'(div_trial - {1'b0, len}) : div_trial[31:0];
			div_d_q <= div_d_q << 1;
			div_quo_q <= {div_quo_q[DIV_W-2:0], div_ge};
		end
		if (cmd.op == OP_EMIT) inside_res_q <= !outside_q;
	end

endmodule

[sv/frustum_plane_extract_and_point_test_unit.sv]
// top level of the frustum plane extraction and point test unit
//
//  channel   direction  handshake              payload
//  in        input      in_valid / in_stall    command, element_index, element_value, point_x/y/z
//  out       output     out_valid / out_stall  inside_res
//  cfg       apb        psel/penable/pwrite    paddr, pwdata, prdata (8 x 64-bit at 8*i)
//
// a view element load is taken without stalling the input; loading element 15 then rebuilds
// the planes (64 products on the shared multiplier, then per plane the raw terms, three squares,
// 32 square root steps and four bit-serial divisions), input stalled meanwhile.
// a point test runs its plane terms on the shared multiplier, then drains and emits the result.
// the result sits in an output register, so a new item is taken while it waits.
// reset restores the identity projection and view and clears the planes.
module frustum_plane_extract_and_point_test_unit import fpe_pkg::*; #(
	parameter int PLANE_COUNT = PLANE_COUNT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   command,
	input  logic [3:0]             element_index,
	input  logic signed [31:0]     element_value,
	input  logic signed [31:0]     point_x,
	input  logic signed [31:0]     point_y,
	input  logic signed [31:0]     point_z,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   inside_res,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_ADDR_W-1:0]  paddr,
	input  logic [APB_DATA_W-1:0]  pwdata,
	output logic [APB_DATA_W-1:0]  prdata,
	output logic                   pready
);

	logic [PAIR_COUNT-1:0][APB_DATA_W-1:0] proj;
	cmd_t cmd;

	fpe_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.proj    (proj)
	);

	fpe_ctrl #(.PLANE_COUNT(PLANE_COUNT)) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.command       (command),
		.element_index (element_index),
		.out_stall     (out_stall),
		.in_stall      (in_stall),
		.out_valid     (out_valid),
		.cmd           (cmd)
	);

	fpe_dp #(.PLANE_COUNT(PLANE_COUNT)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.command       (command),
		.element_index (element_index),
		.element_value (element_value),
		.point_x       (point_x),
		.point_y       (point_y),
		.point_z       (point_z),
		.proj          (proj),
		.inside_res    (inside_res)
	);

endmodule

[sv/fpe_checker.sv]
// port-level checks of the frustum plane unit and their binding
`include "frustum_plane_extract_and_point_test_unit_macros.svh"

module fpe_props import fpe_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       command,
	input logic [3:0] element_index,
	input logic       out_valid,
	input logic       out_stall,
	input logic       inside_res,
	input logic       pready
);

	`FPE_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(inside_res), "stalled result changed")
	`FPE_ASSERT_IMP(a_pready, 1'b1, pready, "pready dropped")
	`FPE_ASSERT_NXT(a_load_quick, in_valid && !in_stall && !command && element_index != LAST_ELEM, !in_stall, "plain load left the unit busy")
	`FPE_ASSERT_NXT(a_test_busy, in_valid && !in_stall && command, in_stall, "point test transfer did not occupy the unit")

endmodule

bind frustum_plane_extract_and_point_test_unit fpe_props u_fpe_props (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.command       (command),
	.element_index (element_index),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.inside_res    (inside_res),
	.pready        (pready)
);

[verif/fpe_checker.sv]
// checker for the frustum plane unit: mirrors view, projection and planes, predicts point tests
`timescale 1ns / 100ps

module fpe_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               command,
	input  logic [3:0]         element_index,
	input  logic signed [31:0] element_value,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               inside_res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [5:0]         paddr,
	input  logic [63:0]        pwdata,
	input  logic               pready,
	output int                 fail_count,
	output int                 pending_tests
);

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TEST = 1'b1;

	logic [63:0] proj_regs [8];
	logic signed [31:0] view_mat [16];
	logic signed [31:0] planes [24];
	logic inside_queue [$];

	function automatic logic signed [31:0] clamp32(input longint x);
		if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (x < -64'sd2147483648) return 32'sh8000_0000;
		return x[31:0];
	endfunction

	function automatic longint proj_at(input int k);
		logic [63:0] pr;
		pr = proj_regs[k >> 1];
		return (k & 1) ? longint'($signed(pr[63:32])) : longint'($signed(pr[31:0]));
	endfunction

	function automatic longint root64(input logic [63:0] n);
		logic [63:0] r, b;
		r = 0;
		b = 64'h1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return longint'(r);
	endfunction

	task automatic rebuild_planes();
		logic signed [31:0] m [16];
		logic signed [31:0] raw [4];
		longint acc, w, e, len;
		logic [63:0] sumsq;
		int row;
		bit add;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				acc = 0;
				// >>> on signed longint floors
				for (int k = 0; k < 4; k++)
					acc += (proj_at(k * 4 + r) * longint'(view_mat[c * 4 + k])) >>> 16;
				m[c * 4 + r] = clamp32(acc);
			end
		end
		for (int i = 0; i < 6; i++) begin
			row = i / 2;
			add = (i == 0) || (i == 3) || (i == 4);
			sumsq = 0;
			for (int c = 0; c < 4; c++) begin
				w = m[c * 4 + 3];
				e = m[c * 4 + row];
				raw[c] = clamp32(add ? w + e : w - e);
			end
			for (int c = 0; c < 3; c++) sumsq += 64'(longint'(raw[c]) * longint'(raw[c]));
			len = root64(sumsq);
			for (int c = 0; c < 4; c++)
				planes[i * 4 + c] = (len == 0) ? 32'sd0 : clamp32((longint'(raw[c]) * 65536) / len);
		end
	endtask

	function automatic logic point_inside(input longint x, input longint y, input longint z);
		longint d;
		for (int i = 0; i < 6; i++) begin
			d = longint'(planes[i * 4]) * x + longint'(planes[i * 4 + 1]) * y
				+ longint'(planes[i * 4 + 2]) * z + longint'(planes[i * 4 + 3]) * 65536;
			if (d <= -y * 65536) return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_count = 0;
			inside_queue.delete();
			pending_tests = 0;
			for (int p = 0; p < 8; p++) proj_regs[p] = 64'd0;
			proj_regs[0] = 64'h1_0000;
			proj_regs[2] = 64'h1_0000 << 32;
			proj_regs[5] = 64'h1_0000;
			proj_regs[7] = 64'h1_0000 << 32;
			for (int k = 0; k < 16; k++) view_mat[k] = ((k & 3) == (k >> 2)) ? 32'sh1_0000 : 0;
			for (int k = 0; k < 24; k++) planes[k] = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (inside_queue.size() == 0) begin
					report_mismatch("result with no test waiting");
				end else begin
					if (inside_res !== inside_queue[0])
						report_mismatch($sformatf("inside_res %0b, expected %0b",
							inside_res, inside_queue[0]));
					void'(inside_queue.pop_front());
				end
			end
			if (psel && penable && pwrite && pready && paddr[2:0] == 3'd0)
				proj_regs[paddr[5:3]] = pwdata;
			if (in_valid && !in_stall) begin
				if (command == CMD_LOAD) begin
					view_mat[element_index] = element_value;
					if (element_index == 4'd15) rebuild_planes();
				end else begin
					inside_queue.push_back(point_inside(point_x, point_y, point_z));
				end
			end
			pending_tests = inside_queue.size();
		end
	end

endmodule

[verif/tb.sv]
// testbench top: drives view loads, point tests and projection writes, gives the verdict
`timescale 1ns / 100ps

module tb import fpe_pkg::*; ();

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TEST = 1'b1;
	localparam int CYCLE_LIMIT = 1500000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0, in_stall;
	logic command = CMD_LOAD;
	logic [3:0] element_index = '0;
	logic signed [31:0] element_value = '0, point_x = '0, point_y = '0, point_z = '0;
	logic out_valid, out_stall = 1'b0, inside_res;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0, prdata;
	logic pready;
	int fail_count, pending_tests;
	int cycle_count = 0;
	int stall_left = 0;
	bit stall_quiet = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	frustum_plane_extract_and_point_test_unit u_dut (.*);

	fpe_checker u_chk (.*);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// output stall runs, mostly short with the odd long one
	always @(negedge clk) begin
		if (stall_quiet) begin
			stall_left = 0;
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			stall_left = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
		end
	end

	function automatic logic [31:0] rnd_q16();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			default: return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
		endcase
	endfunction

	// valid stays high after a transfer until the next item or an idle gap replaces it
	task automatic send(input logic cmd, input logic [3:0] idx, input logic [31:0] val,
		input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		int g;
		g = gap_len();
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		element_index <= idx;
		element_value <= val;
		point_x <= x;
		point_y <= y;
		point_z <= z;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic load_elem(input logic [3:0] idx, input logic [31:0] val);
		send(CMD_LOAD, idx, val, $urandom, $urandom, $urandom);
	endtask

	task automatic test_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		send(CMD_TEST, 4'($urandom), $urandom, x, y, z);
	endtask

	task automatic apb_write(input int idx, input logic [63:0] val);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= APB_ADDR_W'(idx * 8);
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// wait out results and the plane rebuild before touching registers
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_tests != 0) @(posedge clk);
		repeat (1600) @(posedge clk);
	endtask

	task automatic random_view();
		for (int k = 0; k < 16; k++) load_elem(4'(k), rnd_q16());
	endtask

	task automatic frame_phase(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 39) == 0) random_view();
			else if ($urandom_range(0, 19) == 0) load_elem(4'($urandom_range(0, 14)), rnd_q16());
			else test_point(rnd_q16(), rnd_q16(), rnd_q16());
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// planes all zero: point_y decides
		test_point(0, 0, 0);
		test_point(0, 1, 0);
		test_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		test_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		// identity rebuild, then points on and off the unit cube
		load_elem(4'd15, 32'h0001_0000);
		test_point(0, 0, 0);
		test_point(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
		test_point(32'h0002_0000, 0, 0);
		test_point(32'hFFFF_0000, 32'h0001_0000, 0);
		// zero-length normals
		for (int k = 0; k < 16; k++) load_elem(4'(k), 32'd0);
		test_point(5, 5, 5);
		test_point(5, -5, 5);
		// saturating extremes
		for (int k = 0; k < 16; k++) load_elem(4'(k), k[0] ? 32'h7FFF_FFFF : 32'h8000_0000);
		test_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		test_point(1, 2, 3);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			stall_quiet = (ph == 2);
			for (int p = 0; p < 8; p++) begin
				case (ph)
					0: apb_write(p, {$urandom, $urandom});
					1: apb_write(p, {32'h7FFF_FFFF, 32'h8000_0000});
					2: apb_write(p, 64'd0);
					3: apb_write(p, {rnd_q16(), rnd_q16()});
					default: apb_write(p, p == 0 || p == 5 ? PAIR_DIAG_LO :
						p == 2 || p == 7 ? PAIR_DIAG_HI : 64'd0);
				endcase
			end
			// small projection values keep planes meaningful
			if (ph == 3) random_view();
			random_view();
			frame_phase(ph == 4 ? 355 : 140);
			drain();
		end
		stall_quiet = 1'b0;
		drain();
		if (fail_count == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

endmodule

[frustum_plane_extract_and_point_test_unit.f]
+incdir+sv
sv/fpe_pkg.sv
sv/fpe_regs.sv
sv/fpe_ctrl.sv
sv/fpe_dp.sv
sv/frustum_plane_extract_and_point_test_unit.sv
sv/fpe_checker.sv
verif/fpe_checker.sv
verif/tb.sv
